// ----- rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms; empty when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Check an expression at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed: label");

// Check that an antecedent implies a consequent in the same cycle
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: label");

// Check that an antecedent implies a consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: label");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, expr)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- rtl/spq_pkg.sv -----
// ---------------------------------------------------------------------------
// spq_pkg
// Types and constants of the stable priority queue.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package spq_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int OCC_W    = 5;

  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  localparam logic [1:0] ST_ENQUEUED = 2'd0;
  localparam logic [1:0] ST_DEQUEUED = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  typedef struct packed {
    logic               operation;
    logic signed [31:0] value_in;
    logic signed [31:0] priority_in;
  } spq_in_t;

  typedef struct packed {
    logic signed [31:0] value_out;
    logic [1:0]         status;
    logic [OCC_W-1:0]   occupancy;
  } spq_out_t;

  // One queue slot as held by a cell
  typedef struct packed {
    logic               valid;
    logic signed [31:0] value;
    logic signed [31:0] prio;
  } spq_slot_t;

  // Command broadcast to every cell
  typedef struct packed {
    logic               enq;
    logic               deq;
    logic signed [31:0] value;
    logic signed [31:0] prio;
  } spq_cmd_t;

endpackage

// ----- rtl/stable_priority_queue.sv -----
// The result of an item is strobed in the cycle after start is taken.
// Throughput: one item per cycle; each cell compares combinationally and registers its slot.
// busy stays low; the receiver cannot stall, results are strobed for one cycle.
// Reset empties the queue (cell valid bits and the item count cleared).
// ---------------------------------------------------------------------------
// stable_priority_queue
// Bounded stable priority queue built as a row of shifting cells.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module stable_priority_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  spq_pkg::spq_in_t  in_item,
  output logic              out_valid,
  output spq_pkg::spq_out_t out_item
);
  import spq_pkg::*;

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             out_valid_r;
  spq_out_t         out_item_r;
  spq_out_t         out_item_nxt;

  logic      full;
  logic      empty;
  spq_cmd_t  cmd;
  spq_slot_t slot [CAPACITY];
  logic      keep [CAPACITY];
  logic [CAPACITY-1:0] valid_vec;

  assign busy  = 1'b0;
  assign full  = (count_r == CNT_W'(CAPACITY));
  assign empty = (count_r == '0);

  always_comb begin
    cmd.enq   = start && (in_item.operation == OP_ENQ) && !full;
    cmd.deq   = start && (in_item.operation == OP_DEQ) && !empty;
    cmd.value = in_item.value_in;
    cmd.prio  = in_item.priority_in;
  end

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic      left_keep;
      spq_slot_t left_slot;
      spq_slot_t right_slot;

      if (gi == 0) begin : g_head
        assign left_keep = 1'b1;
        assign left_slot = '0;
      end else begin : g_body
        assign left_keep = keep[gi-1];
        assign left_slot = slot[gi-1];
      end

      if (gi == CAPACITY - 1) begin : g_tail
        assign right_slot = '0;
      end else begin : g_next
        assign right_slot = slot[gi+1];
      end

      spq_cell u_cell (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_i        (cmd),
        .left_keep_i  (left_keep),
        .left_slot_i  (left_slot),
        .right_slot_i (right_slot),
        .keep_o       (keep[gi]),
        .slot_o       (slot[gi])
      );

      assign valid_vec[gi] = slot[gi].valid;
    end
  endgenerate

  always_comb begin
    count_nxt              = count_r;
    out_item_nxt.value_out = '0;
    out_item_nxt.status    = ST_ENQUEUED;
    if (in_item.operation == OP_ENQ) begin
      if (full) begin
        out_item_nxt.status = ST_FULL;
      end else begin
        count_nxt = count_r + CNT_W'(1);
      end
    end else begin
      if (empty) begin
        out_item_nxt.status = ST_EMPTY;
      end else begin
        count_nxt              = count_r - CNT_W'(1);
        out_item_nxt.value_out = slot[0].value;
        out_item_nxt.status    = ST_DEQUEUED;
      end
    end
    out_item_nxt.occupancy = OCC_W'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= start;
      if (start) begin
        count_r <= count_nxt;
      end
    end
    if (start) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `ASSERT_ALWAYS(a_count_matches_cells, clk, rst_n, $countones(valid_vec) == int'(count_r))
  `ASSERT_ALWAYS(a_cells_packed_at_head, clk, rst_n, (valid_vec & (valid_vec + CAPACITY'(1))) == '0)
  `ASSERT_IMPLIES(a_full_status_at_capacity, clk, rst_n, out_valid && (out_item.status == ST_FULL), full)
  `ASSERT_NEXT(a_result_follows_start, clk, rst_n, start, out_valid)

endmodule

// ----- rtl/spq_cell.sv -----
// ---------------------------------------------------------------------------
// spq_cell
// One slot of the sorted queue: holds, takes the new item or shifts.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module spq_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  spq_pkg::spq_cmd_t cmd_i,
  input  logic              left_keep_i,
  input  spq_pkg::spq_slot_t left_slot_i,
  input  spq_pkg::spq_slot_t right_slot_i,
  output logic              keep_o,
  output spq_pkg::spq_slot_t slot_o
);
  import spq_pkg::*;

  spq_slot_t slot_r;
  spq_slot_t slot_nxt;

  // Stay put on insert when this entry ranks at or above the new one
  assign keep_o = slot_r.valid && (slot_r.prio >= cmd_i.prio);

  always_comb begin
    slot_nxt = slot_r;
    if (cmd_i.enq) begin
      if (!keep_o) begin
        if (left_keep_i) begin
          slot_nxt.valid = 1'b1;
          slot_nxt.value = cmd_i.value;
          slot_nxt.prio  = cmd_i.prio;
        end else begin
          slot_nxt = left_slot_i;
        end
      end
    end else if (cmd_i.deq) begin
      slot_nxt = right_slot_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r.valid <= 1'b0;
    end else begin
      slot_r.valid <= slot_nxt.valid;
    end
    slot_r.value <= slot_nxt.value;
    slot_r.prio  <= slot_nxt.prio;
  end

  assign slot_o = slot_r;

endmodule

// ----- verif/stable_priority_queue_test.sv -----
// ---------------------------------------------------------------------------
// stable_priority_queue_test
// Drives enqueue and dequeue items into the stable priority queue with random
// gaps, predicts each result from a sorted shadow store and checks every
// strobed result, field by field, against the oldest prediction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module stable_priority_queue_test;
  import spq_pkg::*;

  localparam int IDLE_LIMIT   = 500;
  localparam int RANDOM_ITEMS = 1700;

  typedef struct {
    spq_in_t item;
    int      gap;
  } pending_item_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  spq_in_t  in_item = '0;
  logic     out_valid;
  spq_out_t out_item;

  pending_item_t pending_items[$];
  spq_out_t      expected_results[$];

  // Shadow of the queue contents, highest priority in slot 0
  logic signed [31:0] shadow_value [CAPACITY];
  logic signed [31:0] shadow_prio [CAPACITY];
  int                 shadow_count = 0;

  spq_in_t staged_item = '0;
  logic    have_staged = 1'b0;
  int      wait_cnt = 0;
  int      total_items = 0;
  int      accepted_items = 0;
  int      fail_count = 0;
  int      idle_cycles = 0;

  stable_priority_queue dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  always #10 clk = ~clk;

  function automatic spq_out_t predict_queue(input spq_in_t item);
    spq_out_t r;
    int       pos;
    r.value_out = '0;
    if (item.operation == OP_ENQ) begin
      if (shadow_count >= CAPACITY) begin
        r.status = ST_FULL;
      end else begin
        // place after every entry of greater or equal priority
        pos = 0;
        while (pos < shadow_count &&
               $signed(shadow_prio[pos]) >= $signed(item.priority_in))
          pos++;
        for (int i = shadow_count; i > pos; i--) begin
          shadow_value[i] = shadow_value[i-1];
          shadow_prio[i]  = shadow_prio[i-1];
        end
        shadow_value[pos] = item.value_in;
        shadow_prio[pos]  = item.priority_in;
        shadow_count++;
        r.status = ST_ENQUEUED;
      end
    end else begin
      if (shadow_count == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.value_out = shadow_value[0];
        for (int i = 1; i < shadow_count; i++) begin
          shadow_value[i-1] = shadow_value[i];
          shadow_prio[i-1]  = shadow_prio[i];
        end
        shadow_count--;
        r.status = ST_DEQUEUED;
      end
    end
    r.occupancy = shadow_count[OCC_W-1:0];
    return r;
  endfunction

  function automatic void note_failure(input string what, input spq_out_t want,
                                       input spq_out_t got);
    fail_count++;
    if (fail_count <= 10)
      $display("%0t: %s: expected value %0d status %0d occupancy %0d, got value %0d status %0d occupancy %0d",
               $realtime, what, want.value_out, want.status, want.occupancy,
               got.value_out, got.status, got.occupancy);
  endfunction

  task automatic add_item(input logic op, input logic [31:0] val, input logic [31:0] pri,
                          input int gap);
    pending_item_t p;
    p.item.operation   = op;
    p.item.value_in    = val;
    p.item.priority_in = pri;
    p.gap              = gap;
    pending_items.push_back(p);
  endtask

  // Driver: present items from the pending queue, idling for each item's gap
  always @(posedge clk) begin : drive
    pending_item_t p;
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!(start && busy)) begin
      if (wait_cnt > 0) begin
        start    <= 1'b0;
        wait_cnt <= wait_cnt - 1;
      end else if (have_staged) begin
        in_item     <= staged_item;
        start       <= 1'b1;
        have_staged <= 1'b0;
      end else if (pending_items.size() > 0) begin
        p = pending_items.pop_front();
        if (p.gap == 0) begin
          in_item <= p.item;
          start   <= 1'b1;
        end else begin
          staged_item <= p.item;
          have_staged <= 1'b1;
          start       <= 1'b0;
          wait_cnt    <= p.gap - 1;
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: predict on each accepted item, then check any strobed result
  always @(posedge clk) begin : monitor
    spq_out_t want;
    if (rst_n) begin
      if (start && !busy) begin
        expected_results.push_back(predict_queue(in_item));
        accepted_items++;
      end
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          want = '0;
          note_failure("result with no item pending", want, out_item);
        end else begin
          want = expected_results.pop_front();
          if (out_item.value_out !== want.value_out || out_item.status !== want.status ||
              out_item.occupancy !== want.occupancy)
            note_failure("result mismatch", want, out_item);
        end
      end
    end
  end

  // Watchdog on cycles in which nothing moves
  always @(posedge clk) begin
    if ((rst_n && start && !busy) || (rst_n && out_valid))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    int          phase_len;
    int          enq_pct;
    int          gap_mode;
    int          prio_mode;
    int          gap;
    int          made;
    logic [31:0] pri;
    logic [31:0] prio_edges [5];

    prio_edges = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
                   32'h0000_0001};

    // Directed: empty dequeue, ties, extreme priorities and values, full queue
    add_item(OP_DEQ, 32'h1234_5678, 32'h7FFF_FFFF, 0);
    add_item(OP_ENQ, 32'h7FFF_FFFF, 32'h0000_0000, 0);
    add_item(OP_ENQ, 32'h8000_0000, 32'h0000_0000, 0);
    add_item(OP_ENQ, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 0);
    add_item(OP_ENQ, 32'h0000_0000, 32'h8000_0000, 0);
    add_item(OP_ENQ, 32'h0000_0005, 32'hFFFF_FFFF, 0);
    add_item(OP_ENQ, 32'h0000_0006, 32'h0000_0001, 0);
    add_item(OP_ENQ, 32'h0000_0007, 32'h7FFF_FFFF, 0);
    add_item(OP_ENQ, 32'h0000_0008, 32'h8000_0000, 0);
    for (int i = 0; i < 8; i++)
      add_item(OP_ENQ, 32'hA5A5_0000 + i, (i % 2) ? 32'h0000_0000 : 32'h7FFF_FFFF, 0);
    add_item(OP_ENQ, 32'hDEAD_BEEF, 32'h7FFF_FFFF, 0);
    add_item(OP_DEQ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
    add_item(OP_DEQ, 32'h0000_0000, 32'h0000_0000, 0);
    add_item(OP_DEQ, 32'h5555_5555, 32'hAAAA_AAAA, 0);

    // Random: phases that lean towards filling, draining or neither
    made = 0;
    while (made < RANDOM_ITEMS) begin
      phase_len = $urandom_range(120, 20);
      case ($urandom_range(2, 0))
        0:       enq_pct = 80;
        1:       enq_pct = 20;
        default: enq_pct = 50;
      endcase
      gap_mode  = $urandom_range(2, 0);
      prio_mode = $urandom_range(2, 0);
      for (int k = 0; k < phase_len && made < RANDOM_ITEMS; k++) begin
        case (prio_mode)
          0:       pri = $urandom_range(3, 0) - 1;
          1:       pri = prio_edges[$urandom_range(4, 0)];
          default: pri = $urandom;
        endcase
        case (gap_mode)
          0:       gap = 0;
          1:       gap = $urandom_range(13, 0);
          default: gap = ($urandom_range(9, 0) == 0) ? $urandom_range(13, 0) : 0;
        endcase
        add_item(($urandom_range(99, 0) < enq_pct) ? OP_ENQ : OP_DEQ, $urandom, pri, gap);
        made++;
      end
    end
    total_items = pending_items.size();

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (accepted_items < total_items || expected_results.size() > 0)
      @(posedge clk);
    repeat (4) @(posedge clk);

    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/stable_priority_queue.sv
verif/stable_priority_queue_test.sv
